// File: design/checkpoint_predecessor_table_assert.svh
// assertion macros for the checkpoint predecessor table checker
`ifndef CHECKPOINT_PREDECESSOR_TABLE_ASSERT_SVH
`define CHECKPOINT_PREDECESSOR_TABLE_ASSERT_SVH

// concurrent check, quiet while reset is high
`define CPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds around reset
`define CPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cpt_pkg.sv
// shared types and constants for the checkpoint predecessor table
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_OFFSET_BITS = 32;
   localparam int PORT_BITS       = 32;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic   clear;
      logic   valid;
      op_type op;
   } scan_ctl_type;

endpackage

`default_nettype wire

// File: design/checkpoint_predecessor_table.sv
// top level of the checkpoint predecessor table
//
// bounded table of page-start byte offsets with a predecessor search
// input channel: an item is taken at a clock edge where start is high and
//   busy is low; req_operation selects insert or query, req_offset carries
//   the offset to insert or the key to search below
// insert: adds the offset unless it is already stored (rsp_found = 1 then);
//   slots fill in order, and once full the oldest slot is replaced round robin
// query: rsp_found tells whether some stored offset lies strictly below the
//   key, rsp_nearest_below gives the greatest such offset (zero otherwise)
// result channel: rsp_strobe is high for exactly one cycle per item; the
//   receiver cannot stall, so results never wait
// timing: one compare unit walks the stored entries one per cycle through the
//   registered read port of the table memory; the sequencer steps through
//   ST_SCAN, ST_DRAIN and ST_RESP and the strobe is registered from ST_RESP,
//   while an empty table goes straight to ST_RESP; busy drops in the
//   strobe cycle so the next item can go in at its end
// reset: fill count and replace pointer clear, the sequencer returns to idle;
//   the memory itself is not cleared, only slots below the fill count are read
`timescale 1ns / 1ps
`default_nettype none

module checkpoint_predecessor_table #(
   parameter int TABLE_DEPTH = cpt_pkg::DEF_TABLE_DEPTH,
   parameter int OFFSET_BITS = cpt_pkg::DEF_OFFSET_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic                          req_operation,
   input  wire logic [cpt_pkg::PORT_BITS-1:0] req_offset,
   output      logic                          rsp_strobe,
   output      logic                          rsp_found,
   output      logic [cpt_pkg::PORT_BITS-1:0] rsp_nearest_below
);
   import cpt_pkg::*;

   localparam int AddrBits  = $clog2(TABLE_DEPTH);
   localparam int CountBits = $clog2(TABLE_DEPTH + 1);
   // bits of the port that survive into a stored offset
   localparam int KeepBits  = (OFFSET_BITS < PORT_BITS) ? OFFSET_BITS : PORT_BITS;

   // sequencer state
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [OFFSET_BITS-1:0] key_ff, key_in;
   logic [AddrBits-1:0]    idx_ff, idx_in;
   logic                   rd_vld_ff;

   // table bookkeeping
   logic [CountBits-1:0]   fill_ff, fill_in;
   logic [AddrBits-1:0]    repl_ff, repl_in;

   // result registers
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [PORT_BITS-1:0]   rsp_near_ff, rsp_near_in;

   logic                   accept;
   logic                   last_read;
   logic                   table_full;
   logic                   rd_en;
   logic                   wr_en;
   logic [AddrBits-1:0]    wr_addr;
   logic [OFFSET_BITS-1:0] rd_data;
   logic [OFFSET_BITS-1:0] req_key;
   logic                   scan_found;
   logic [OFFSET_BITS-1:0] scan_best;
   scan_ctl_type           scan_ctl;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign req_key    = OFFSET_BITS'(req_offset[KeepBits-1:0]);
   assign last_read  = ((CountBits'(idx_ff) + CountBits'(1)) == fill_ff);
   assign table_full = (fill_ff == CountBits'(TABLE_DEPTH));
   assign rd_en      = (state_ff == ST_SCAN);

   // insert of a new value: append while filling, else replace oldest
   assign wr_en   = (state_ff == ST_RESP) && (op_ff == OP_INSERT) && !scan_found;
   assign wr_addr = table_full ? repl_ff : fill_ff[AddrBits-1:0];

   assign scan_ctl.clear = accept;
   assign scan_ctl.valid = rd_vld_ff;
   assign scan_ctl.op    = op_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      repl_in       = repl_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_near_in   = rsp_near_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = op_type'(req_operation);
               key_in = req_key;
               idx_in = '0;
               // empty table: nothing to walk
               state_in = (fill_ff == '0) ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + AddrBits'(1);
            if (last_read) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read word reaches the compare unit
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_found_in  = scan_found;
            rsp_near_in   = (op_ff == OP_QUERY && scan_found) ?
                            PORT_BITS'(scan_best[KeepBits-1:0]) : '0;
            if (wr_en) begin
               if (table_full) begin
                  repl_in = (repl_ff == AddrBits'(TABLE_DEPTH - 1)) ?
                            '0 : repl_ff + AddrBits'(1);
               end else begin
                  fill_in = fill_ff + CountBits'(1);
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         repl_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         repl_ff       <= repl_in;
         rd_vld_ff     <= rd_en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_near_ff  <= rsp_near_in;
   end

   cpt_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   cpt_scan #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .entry (rd_data),
      .key   (key_ff),
      .found (scan_found),
      .best  (scan_best)
   );

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_nearest_below = rsp_near_ff;

endmodule

`default_nettype wire

// File: design/cpt_store.sv
// offset storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module cpt_store #(
   parameter int TABLE_DEPTH = 16,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  wire logic [OFFSET_BITS-1:0]         wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output      logic [OFFSET_BITS-1:0]         rd_data
);

   logic [OFFSET_BITS-1:0] mem_ff [TABLE_DEPTH];
   logic [OFFSET_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/cpt_scan.sv
// shared compare unit: equality for inserts, running predecessor for queries
`timescale 1ns / 1ps
`default_nettype none

module cpt_scan #(
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cpt_pkg::scan_ctl_type  ctl,
   input  wire logic [OFFSET_BITS-1:0] entry,
   input  wire logic [OFFSET_BITS-1:0] key,
   output      logic                   found,
   output      logic [OFFSET_BITS-1:0] best
);
   import cpt_pkg::*;

   logic                   found_ff;
   logic                   found_in;
   logic [OFFSET_BITS-1:0] best_ff;
   logic [OFFSET_BITS-1:0] best_in;
   logic                   is_equal;
   logic                   is_below;
   logic                   beats_best;

   assign is_equal   = (entry == key);
   assign is_below   = (entry < key);
   assign beats_best = !found_ff || (entry > best_ff);

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
         best_in  = '0;
      end else if (ctl.valid) begin
         case (ctl.op)
            OP_INSERT: begin
               if (is_equal) begin
                  found_in = 1'b1;
               end
            end
            OP_QUERY: begin
               if (is_below && beats_best) begin
                  found_in = 1'b1;
                  best_in  = entry;
               end
            end
            default: begin
               found_in = found_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign found = found_ff;
   assign best  = best_ff;

endmodule

`default_nettype wire

// File: design/cpt_check.sv
// port-level checks for the checkpoint predecessor table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "checkpoint_predecessor_table_assert.svh"

module cpt_check (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_operation,
   input wire logic [cpt_pkg::PORT_BITS-1:0] req_offset,
   input wire logic                          rsp_strobe,
   input wire logic                          rsp_found,
   input wire logic [cpt_pkg::PORT_BITS-1:0] rsp_nearest_below
);

   logic req_seen;
   assign req_seen = req_operation || (req_offset != '0) || !req_operation;

   // an accepted item keeps the block busy in the following cycle
   `CPT_ASSERT(a_accept_busy, clock, reset, start && !busy && req_seen |=> busy, "accepted item did not raise busy")

   // one result per item, never two strobes back to back
   `CPT_ASSERT(a_single_strobe, clock, reset, rsp_strobe |=> !rsp_strobe, "strobe held for two cycles")

   // a result always follows a busy stretch
   `CPT_ASSERT(a_strobe_after_busy, clock, reset, rsp_strobe |-> $past(busy), "strobe without a busy item")

   // no predecessor found means the offset reads zero
   `CPT_ASSERT(a_zero_when_missing, clock, reset, rsp_strobe && !rsp_found |-> rsp_nearest_below == '0, "nonzero offset without found")

   // reset leaves the block idle and silent
   `CPT_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy && !rsp_strobe, "block not idle after reset")

endmodule

bind checkpoint_predecessor_table cpt_check u_cpt_check (.*);

`default_nettype wire

// File: bench/tb_top.sv
// self-checking testbench for the checkpoint predecessor table
`timescale 1ns / 1ps

module tb_top;
   import cpt_pkg::*;

   localparam int SLOTS = DEF_TABLE_DEPTH;
   localparam int OBITS = PORT_BITS;

   typedef logic [OBITS-1:0] offset_type;

   // what one item should return
   typedef struct {
      logic       found;
      offset_type nearest_below;
   } lookup_result_type;

   // shadow copy of the offset table; computes the answer for every item
   // that the block accepts and holds the answers until their strobes come
   class lookup_scoreboard;
      offset_type        slots[SLOTS];
      int unsigned       fill_count;
      int unsigned       replace_ptr;
      lookup_result_type pending_lookups[$];
      int unsigned       fails;

      function new();
         fill_count  = 0;
         replace_ptr = 0;
         fails       = 0;
      endfunction

      function int unsigned pending();
         return pending_lookups.size();
      endfunction

      // work out the answer for an accepted item and update the shadow table
      function void note_item(op_type op, offset_type key);
         lookup_result_type res;
         bit                present;
         res.found         = 1'b0;
         res.nearest_below = '0;
         present           = 1'b0;
         if (op == OP_INSERT) begin
            for (int i = 0; i < fill_count; i++)
               if (slots[i] == key) present = 1'b1;
            if (present) begin
               res.found = 1'b1;
            end else if (fill_count < SLOTS) begin
               slots[fill_count] = key;
               fill_count++;
            end else begin
               // full: overwrite the oldest slot, round robin
               slots[replace_ptr] = key;
               replace_ptr = (replace_ptr + 1) % SLOTS;
            end
         end else begin
            // strictly below the key; an equal entry does not count
            for (int i = 0; i < fill_count; i++)
               if (slots[i] < key && (!res.found || slots[i] > res.nearest_below)) begin
                  res.nearest_below = slots[i];
                  res.found         = 1'b1;
               end
         end
         pending_lookups.push_back(res);
      endfunction

      // compare one strobed result with the oldest answer
      function void check_result(logic found, offset_type nearest_below);
         lookup_result_type exp_res;
         if (pending_lookups.size() == 0) begin
            $error("unexpected result: rsp_found %0d, rsp_nearest_below %h",
                   found, nearest_below);
            fails++;
            return;
         end
         exp_res = pending_lookups.pop_front();
         if (found !== exp_res.found) begin
            $error("rsp_found: expected %0d, actual %0d", exp_res.found, found);
            fails++;
         end
         if (nearest_below !== exp_res.nearest_below) begin
            $error("rsp_nearest_below: expected %h, actual %h",
                   exp_res.nearest_below, nearest_below);
            fails++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_operation;
   offset_type req_offset;
   logic       rsp_strobe;
   logic       rsp_found;
   offset_type rsp_nearest_below;

   lookup_scoreboard sb = new();

   // recently inserted offsets, reused so that duplicates and equal keys turn up
   offset_type inserted_offsets[$];

   checkpoint_predecessor_table i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_offset        (req_offset),
      .rsp_strobe        (rsp_strobe),
      .rsp_found         (rsp_found),
      .rsp_nearest_below (rsp_nearest_below)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // monitor: values read here are the ones from before the edge
   // the result is checked ahead of the new item, since an item can be taken
   // in the very cycle that the previous one strobes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_result(rsp_found, rsp_nearest_below);
         if (start && !busy)
            sb.note_item(op_type'(req_operation), req_offset);
      end
   end

   // present one item and hold it until the block takes it
   // idle_pct: chance in a hundred of a dead cycle before the item
   task automatic send_item(input op_type op, input offset_type off, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_offset    <= off;
      if (op == OP_INSERT) begin
         inserted_offsets.push_back(off);
         if (inserted_offsets.size() > 64) void'(inserted_offsets.pop_front());
      end
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and let every outstanding item come back
   // checked on the falling edge so the monitor has already run
   task automatic wait_for_results();
      start <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   // key mix: full random for bit coverage, reuse of stored values (and their
   // neighbors) to hit duplicates and equal keys, and values at both ends
   function automatic offset_type pick_offset();
      int unsigned sel;
      offset_type  v;
      sel = $urandom_range(99);
      if (sel < 30 || inserted_offsets.size() == 0)
         v = $urandom();
      else if (sel < 50)
         v = inserted_offsets[$urandom_range(inserted_offsets.size() - 1)];
      else if (sel < 60)
         v = inserted_offsets[$urandom_range(inserted_offsets.size() - 1)]
             + offset_type'($urandom_range(2)) - offset_type'(1);
      else if (sel < 75)
         v = offset_type'($urandom_range(63));
      else if (sel < 90)
         v = '1 - offset_type'($urandom_range(63));
      else begin
         case ($urandom_range(2))
            0:       v = '0;
            1:       v = '1;
            default: v = offset_type'(1) << (OBITS - 1);
         endcase
      end
      return v;
   endfunction

   // random mix of inserts and queries
   task automatic run_phase(input int n_items, input int idle_pct);
      op_type op;
      for (int k = 0; k < n_items; k++) begin
         op = op_type'($urandom_range(1));
         send_item(op, pick_offset(), idle_pct);
      end
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_INSERT;
      req_offset    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table first, key zero and all-ones key
      send_item(OP_QUERY,  '0, 0);
      send_item(OP_QUERY,  '1, 0);
      // first insert, then the same value again (duplicate)
      send_item(OP_INSERT, '0, 0);
      send_item(OP_INSERT, '0, 0);
      // equal key does not count as below; key one finds the zero entry
      send_item(OP_QUERY,  '0, 0);
      send_item(OP_QUERY,  offset_type'(1), 0);
      send_item(OP_INSERT, '1, 0);
      send_item(OP_QUERY,  '1, 0);
      send_item(OP_INSERT, offset_type'(1) << (OBITS - 1), 0);
      send_item(OP_INSERT, ~(offset_type'(1) << (OBITS - 1)), 0);
      send_item(OP_QUERY,  '1, 0);
      // fill the rest of the table
      for (int k = 1; k <= SLOTS - 4; k++)
         send_item(OP_INSERT, offset_type'(32'h1111_1111 * k), 0);
      // table full: these replace the two oldest slots (zero and all-ones)
      send_item(OP_INSERT, offset_type'(32'h0000_0005), 0);
      send_item(OP_INSERT, offset_type'(32'hFFFF_FFF0), 0);
      send_item(OP_QUERY,  offset_type'(1), 0);
      send_item(OP_QUERY,  '1, 0);
      wait_for_results();

      // random part: sender idles rarely, then often, then never
      run_phase(330, 15);
      wait_for_results();
      run_phase(330, 59);
      wait_for_results();
      run_phase(340, 0);
      wait_for_results();

      // a few more cycles in case anything stray comes out
      repeat (25) @(posedge clock);
      if (sb.fails == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
